/* rtl/imufp_pkg.sv */
// Shared types and constants for the IMU serial frame parser.
// No dependencies; imported by every module of the block.
package imufp_pkg;

  localparam int unsigned FRAME_BYTES = 11;
  localparam int unsigned DATA_BYTES  = FRAME_BYTES - 3;  // payload between type and checksum
  localparam int unsigned POS_W       = $clog2(FRAME_BYTES);
  localparam int unsigned DIDX_W      = $clog2(DATA_BYTES);
  localparam int unsigned FS_W        = 13;
  localparam int unsigned AXIS_W      = 28;
  localparam int unsigned WORD_W      = 16;
  localparam int unsigned CNT_W       = 32;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned OUT_BITS    = 2 + 1 + 3 * AXIS_W + WORD_W + 2 * CNT_W;
  localparam int unsigned OUT_DATA_W  = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [7:0] HDR_BYTE   = 8'h55;
  localparam logic [7:0] TYPE_ACCEL = 8'h51;
  localparam logic [7:0] TYPE_GYRO  = 8'h52;
  localparam logic [7:0] TYPE_ANGLE = 8'h53;

  localparam logic [POS_W-1:0] POS_HDR  = POS_W'(0);
  localparam logic [POS_W-1:0] POS_TYPE = POS_W'(1);
  localparam logic [POS_W-1:0] POS_CSUM = POS_W'(FRAME_BYTES - 1);

  localparam logic [FS_W-1:0] FS_MAX       = FS_W'(4096);
  localparam logic [FS_W-1:0] FS_ACCEL_RST = FS_W'(16);
  localparam logic [FS_W-1:0] FS_GYRO_RST  = FS_W'(2000);
  localparam logic [FS_W-1:0] FS_ANGLE_RST = FS_W'(180);

  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_FS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_GYRO_FS  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_FS = CFG_IDX_W'(2);

  localparam logic [1:0] KIND_ACCEL = 2'd0;
  localparam logic [1:0] KIND_GYRO  = 2'd1;
  localparam logic [1:0] KIND_ANGLE = 2'd2;

  // One completed frame, handed from the assembler to the scaler.
  typedef struct packed {
    logic [1:0]        kind;
    logic              ok;
    logic [WORD_W-1:0] word_x;
    logic [WORD_W-1:0] word_y;
    logic [WORD_W-1:0] word_z;
    logic [WORD_W-1:0] temp;
    logic [CNT_W-1:0]  good_cnt;
    logic [CNT_W-1:0]  bad_cnt;
  } frame_t;

  function automatic logic [FS_W-1:0] fs_clamp(input logic [FS_W-1:0] fs);
    fs_clamp = (fs > FS_MAX) ? FS_MAX : fs;
  endfunction

endpackage

/* rtl/imufp_frame_asm.sv */
// Byte-level frame hunter: header/type sync, running checksum, payload capture.
// Depends on imufp_pkg. Emits one frame_t per completed frame.
module imufp_frame_asm import imufp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       byte_valid_i,
  output logic       byte_ready_o,
  input  logic [7:0] byte_i,
  output logic       frm_valid_o,
  input  logic       frm_ready_i,
  output frame_t     frm_o
);

  logic [POS_W-1:0] pos_q, pos_d;
  logic [7:0]       sum_q, sum_d;
  logic [1:0]       kind_q, kind_d;
  logic [7:0]       data_q [DATA_BYTES];
  logic             frm_valid_q, frm_valid_d;
  frame_t           frm_q, frm_d;
  logic [CNT_W-1:0] good_q, good_d, bad_q, bad_d;
  logic             acc, data_we, done;
  logic [DIDX_W-1:0] didx;

  assign byte_ready_o = !frm_valid_q || frm_ready_i;
  assign acc          = byte_valid_i && byte_ready_o;
  assign didx         = DIDX_W'(pos_q - POS_W'(2));

  always_comb begin
    pos_d   = pos_q;
    sum_d   = sum_q;
    kind_d  = kind_q;
    data_we = 1'b0;
    done    = 1'b0;
    if (acc) begin
      if (pos_q == POS_HDR || pos_q > POS_CSUM) begin
        pos_d = (byte_i == HDR_BYTE) ? POS_TYPE : POS_HDR;
        sum_d = HDR_BYTE;
      end else if (pos_q == POS_TYPE) begin
        case (byte_i)
          TYPE_ACCEL: begin
            kind_d = KIND_ACCEL;
            pos_d  = pos_q + POS_W'(1);
            sum_d  = sum_q + byte_i;
          end
          TYPE_GYRO: begin
            kind_d = KIND_GYRO;
            pos_d  = pos_q + POS_W'(1);
            sum_d  = sum_q + byte_i;
          end
          TYPE_ANGLE: begin
            kind_d = KIND_ANGLE;
            pos_d  = pos_q + POS_W'(1);
            sum_d  = sum_q + byte_i;
          end
          default: begin
            // resync; a repeated header byte keeps us waiting for a type
            pos_d = (byte_i == HDR_BYTE) ? POS_TYPE : POS_HDR;
            sum_d = HDR_BYTE;
          end
        endcase
      end else if (pos_q == POS_CSUM) begin
        pos_d = POS_HDR;
        done  = 1'b1;
      end else begin
        data_we = 1'b1;
        pos_d   = pos_q + POS_W'(1);
        sum_d   = sum_q + byte_i;
      end
    end
  end

  always_comb begin
    good_d      = good_q;
    bad_d       = bad_q;
    frm_d       = frm_q;
    frm_valid_d = frm_valid_q && !frm_ready_i;
    if (done) begin
      frm_valid_d = 1'b1;
      frm_d       = '0;
      if (sum_q == byte_i) begin
        good_d         = good_q + CNT_W'(1);
        frm_d.ok       = 1'b1;
        frm_d.kind     = kind_q;
        frm_d.word_x   = {data_q[1], data_q[0]};
        frm_d.word_y   = {data_q[3], data_q[2]};
        frm_d.word_z   = {data_q[5], data_q[4]};
        frm_d.temp     = {data_q[7], data_q[6]};
        frm_d.good_cnt = good_d;
      end else begin
        bad_d         = bad_q + CNT_W'(1);
        frm_d.bad_cnt = bad_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= POS_HDR;
      sum_q       <= '0;
      kind_q      <= KIND_ACCEL;
      frm_valid_q <= 1'b0;
      good_q      <= '0;
      bad_q       <= '0;
    end else begin
      pos_q       <= pos_d;
      sum_q       <= sum_d;
      kind_q      <= kind_d;
      frm_valid_q <= frm_valid_d;
      good_q      <= good_d;
      bad_q       <= bad_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (data_we) data_q[didx] <= byte_i;
    frm_q <= frm_d;
  end

  assign frm_valid_o = frm_valid_q;
  assign frm_o       = frm_q;

endmodule

/* rtl/imufp_scale.sv */
// Result stage: picks the full scale by frame kind, scales the three axes,
// and holds the packed result beat. Depends on imufp_pkg.
module imufp_scale import imufp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  frm_valid_i,
  output logic                  frm_ready_o,
  input  frame_t                frm_i,
  input  logic [FS_W-1:0]       fs_accel_i,
  input  logic [FS_W-1:0]       fs_gyro_i,
  input  logic [FS_W-1:0]       fs_angle_i,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output logic [OUT_DATA_W-1:0] res_data_o
);

  logic [FS_W-1:0]       fs;
  logic signed [FS_W:0]  fs_s;
  logic signed [WORD_W+FS_W:0] px, py, pz;
  logic                  valid_q;
  logic [OUT_DATA_W-1:0] data_q, data_d;

  always_comb begin
    case (frm_i.kind)
      KIND_ACCEL: fs = fs_accel_i;
      KIND_GYRO:  fs = fs_gyro_i;
      default:    fs = fs_angle_i;
    endcase
  end

  assign fs_s = signed'({1'b0, fs_clamp(fs)});
  assign px   = (WORD_W+FS_W+1)'(signed'(frm_i.word_x)) * (WORD_W+FS_W+1)'(fs_s);
  assign py   = (WORD_W+FS_W+1)'(signed'(frm_i.word_y)) * (WORD_W+FS_W+1)'(fs_s);
  assign pz   = (WORD_W+FS_W+1)'(signed'(frm_i.word_z)) * (WORD_W+FS_W+1)'(fs_s);

  // fields from bit 0 up: kind, ok, x, y, z, temp, good count, bad count
  assign data_d = OUT_DATA_W'({frm_i.bad_cnt, frm_i.good_cnt, frm_i.temp,
                               pz[AXIS_W-1:0], py[AXIS_W-1:0], px[AXIS_W-1:0],
                               frm_i.ok, frm_i.kind});

  assign frm_ready_o = !valid_q || res_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (frm_ready_o) begin
      valid_q <= frm_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (frm_ready_o && frm_valid_i) data_q <= data_d;
  end

  assign res_valid_o = valid_q;
  assign res_data_o  = data_q;

endmodule

/* rtl/imu_serial_frame_parser.sv */
// Top level of the IMU serial frame parser: config registers, frame assembler
// and result stage. Depends on imufp_pkg, imufp_frame_asm, imufp_scale.
//
//  channel   dir  width  content
//  s_axis    in   8      rx_byte
//  m_axis    out  168    frame result (see m_axis_tdata)
//  cfg       in   13     full-scale registers, index 0..2
//
// One byte beat per cycle; tready stays high unless a completed frame is
// stuck behind a full output register. After its checksum beat, a frame's result
// is registered in the frame register, then in the result register.
// Reset clears sync position, counters and valids; config returns to defaults.
module imu_serial_frame_parser import imufp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // [7:0] rx_byte
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [1:0] frame_kind, [2] checksum_ok, [30:3] axis_x_scaled, [58:31] axis_y_scaled,
  // [86:59] axis_z_scaled, [102:87] temp_word, [134:103] good_frame_total,
  // [166:135] bad_checksum_total, [167] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [FS_W-1:0]       cfg_data_i
);

  logic [FS_W-1:0] fs_accel_q, fs_gyro_q, fs_angle_q;
  logic            frm_valid, frm_ready;
  frame_t          frm;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fs_accel_q <= FS_ACCEL_RST;
      fs_gyro_q  <= FS_GYRO_RST;
      fs_angle_q <= FS_ANGLE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ACCEL_FS: fs_accel_q <= cfg_data_i;
        CFG_GYRO_FS:  fs_gyro_q  <= cfg_data_i;
        CFG_ANGLE_FS: fs_angle_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  imufp_frame_asm u_asm (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (s_axis_tvalid),
    .byte_ready_o (s_axis_tready),
    .byte_i       (s_axis_tdata),
    .frm_valid_o  (frm_valid),
    .frm_ready_i  (frm_ready),
    .frm_o        (frm)
  );

  imufp_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .frm_valid_i (frm_valid),
    .frm_ready_o (frm_ready),
    .frm_i       (frm),
    .fs_accel_i  (fs_accel_q),
    .fs_gyro_i   (fs_gyro_q),
    .fs_angle_i  (fs_angle_q),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_data_o  (m_axis_tdata)
  );

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// Testbench for imu_serial_frame_parser. Streams received bytes, predicts each frame
// result in place and checks every result beat. Depends on imufp_pkg and the RTL.
module tb_top;
  import imufp_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_NONE = CFG_IDX_W'(3);  // no register behind it

  typedef struct packed {
    logic [1:0]        kind;
    logic              ok;
    logic [AXIS_W-1:0] x;
    logic [AXIS_W-1:0] y;
    logic [AXIS_W-1:0] z;
    logic [WORD_W-1:0] temp;
    logic [CNT_W-1:0]  good;
    logic [CNT_W-1:0]  bad;
  } imu_result_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [FS_W-1:0]       cfg_data_i;

  imu_serial_frame_parser DUT (.*);

  // frame tracker state
  logic [POS_W-1:0] frame_pos;
  logic [7:0]       frame_buf [FRAME_BYTES];
  logic [CNT_W-1:0] good_count;
  logic [CNT_W-1:0] bad_count;
  logic [FS_W-1:0]  full_scale [3];

  imu_result_t frame_results_due[$];
  int errors;
  int bytes_sent;
  int idle_pct;
  int stall_pct;
  imu_result_t want;
  imu_result_t got;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("tb_top: errors");
    $finish;
  end

  initial begin
    m_axis_tready <= 1'b1;
    forever begin
      @(posedge clk_i);
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic logic [AXIS_W-1:0] scale_word(input logic [WORD_W-1:0] w,
                                                   input logic [FS_W-1:0] fs);
    logic signed [31:0] p;
    p = 32'($signed(w)) * $signed({19'b0, fs});
    return p[AXIS_W-1:0];
  endfunction

  // Advances the tracker by one byte; returns 1 when the byte closes a frame.
  function automatic bit parse_byte(input logic [7:0] b, output imu_result_t r);
    logic [7:0]      sum;
    logic [FS_W-1:0] fs;
    r = '0;
    if (frame_pos > POS_CSUM) frame_pos = POS_HDR;
    if (frame_pos == POS_HDR) begin
      if (b == HDR_BYTE) begin
        frame_buf[0] = b;
        frame_pos = POS_TYPE;
      end
      return 1'b0;
    end
    if (frame_pos == POS_TYPE && b != TYPE_ACCEL && b != TYPE_GYRO && b != TYPE_ANGLE) begin
      // unknown type: a second header byte keeps sync, anything else drops it
      frame_buf[0] = HDR_BYTE;
      frame_pos = (b == HDR_BYTE) ? POS_TYPE : POS_HDR;
      return 1'b0;
    end
    frame_buf[frame_pos] = b;
    if (frame_pos != POS_CSUM) begin
      frame_pos = frame_pos + POS_W'(1);
      return 1'b0;
    end
    frame_pos = POS_HDR;
    sum = '0;
    for (int i = 0; i < FRAME_BYTES - 1; i++) sum = sum + frame_buf[i];
    if (sum != frame_buf[FRAME_BYTES-1]) begin
      bad_count = bad_count + CNT_W'(1);
      r.bad = bad_count;
      return 1'b1;
    end
    case (frame_buf[1])
      TYPE_ACCEL: begin
        fs = full_scale[CFG_ACCEL_FS];
        r.kind = KIND_ACCEL;
      end
      TYPE_GYRO: begin
        fs = full_scale[CFG_GYRO_FS];
        r.kind = KIND_GYRO;
      end
      default: begin
        fs = full_scale[CFG_ANGLE_FS];
        r.kind = KIND_ANGLE;
      end
    endcase
    if (fs > FS_MAX) fs = FS_MAX;
    good_count = good_count + CNT_W'(1);
    r.ok = 1'b1;
    r.x = scale_word({frame_buf[3], frame_buf[2]}, fs);
    r.y = scale_word({frame_buf[5], frame_buf[4]}, fs);
    r.z = scale_word({frame_buf[7], frame_buf[6]}, fs);
    r.temp = {frame_buf[9], frame_buf[8]};
    r.good = good_count;
    return 1'b1;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // Result beats complete at the next rising edge; inputs are stable by the falling one.
  always @(negedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.kind = m_axis_tdata[1:0];
      got.ok   = m_axis_tdata[2];
      got.x    = m_axis_tdata[30:3];
      got.y    = m_axis_tdata[58:31];
      got.z    = m_axis_tdata[86:59];
      got.temp = m_axis_tdata[102:87];
      got.good = m_axis_tdata[134:103];
      got.bad  = m_axis_tdata[166:135];
      if (frame_results_due.size() == 0) begin
        $display("%0t unexpected result beat: expected none, actual %h", $time, got);
        errors++;
      end else begin
        want = frame_results_due.pop_front();
        check_field("frame_kind", 32'(want.kind), 32'(got.kind));
        check_field("checksum_ok", 32'(want.ok), 32'(got.ok));
        check_field("axis_x_scaled", 32'(want.x), 32'(got.x));
        check_field("axis_y_scaled", 32'(want.y), 32'(got.y));
        check_field("axis_z_scaled", 32'(want.z), 32'(got.z));
        check_field("temp_word", 32'(want.temp), 32'(got.temp));
        check_field("good_frame_total", want.good, got.good);
        check_field("bad_checksum_total", want.bad, got.bad);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    imu_result_t r;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(negedge clk_i);
    while (!s_axis_tready) @(negedge clk_i);
    if (parse_byte(b, r)) frame_results_due.push_back(r);
    bytes_sent++;
    @(posedge clk_i);
  endtask

  task automatic send_frame(input logic [7:0] kind_byte, input logic [15:0] x, y, z, t,
                            input bit corrupt);
    logic [7:0] f [FRAME_BYTES];
    logic [7:0] sum;
    f[0] = HDR_BYTE;
    f[1] = kind_byte;
    {f[3], f[2]} = x;
    {f[5], f[4]} = y;
    {f[7], f[6]} = z;
    {f[9], f[8]} = t;
    sum = '0;
    for (int i = 0; i < FRAME_BYTES - 1; i++) sum = sum + f[i];
    f[FRAME_BYTES-1] = corrupt ? sum + 8'($urandom_range(1, 255)) : sum;
    foreach (f[i]) send_byte(f[i]);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [FS_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx != CFG_NONE) full_scale[idx] = val;
    @(posedge clk_i);
  endtask

  // Hold the byte stream until every pending frame result is out, then let the pipe empty.
  task automatic settle_block();
    s_axis_tvalid <= 1'b0;
    while (frame_results_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_word();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'hFFFF;
      3: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] rand_kind();
    case ($urandom_range(2))
      0: return TYPE_ACCEL;
      1: return TYPE_GYRO;
      default: return TYPE_ANGLE;
    endcase
  endfunction

  function automatic logic [7:0] rand_unknown_type();
    logic [7:0] b;
    if ($urandom_range(2) == 0) return HDR_BYTE;
    do b = 8'($urandom); while (b == TYPE_ACCEL || b == TYPE_GYRO || b == TYPE_ANGLE);
    return b;
  endfunction

  task automatic run_traffic(input int idle, input int stall, input int nbytes);
    int stop_at;
    int roll;
    idle_pct  = idle;
    stall_pct = stall;
    stop_at   = bytes_sent + nbytes;
    while (bytes_sent < stop_at) begin
      roll = $urandom_range(99);
      if (roll < 70) begin
        send_frame(rand_kind(), rand_word(), rand_word(), rand_word(), rand_word(), 1'b0);
      end else if (roll < 80) begin
        send_frame(rand_kind(), rand_word(), rand_word(), rand_word(), rand_word(), 1'b1);
      end else if (roll < 88) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
      end else if (roll < 94) begin
        // cut-off frame; whatever follows is taken as its tail
        send_byte(HDR_BYTE);
        send_byte(rand_kind());
        repeat ($urandom_range(0, 8)) send_byte(8'($urandom));
      end else begin
        send_byte(HDR_BYTE);
        send_byte(rand_unknown_type());
      end
    end
    settle_block();
    idle_pct  = 0;
    stall_pct = 0;
  endtask

  task automatic test_frame_kinds();
    send_frame(TYPE_ACCEL, 16'h8000, 16'h7FFF, 16'h0000, 16'h8000, 1'b0);
    send_frame(TYPE_GYRO, 16'hFFFF, 16'h0001, 16'h8000, 16'h7FFF, 1'b0);
    send_frame(TYPE_ANGLE, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000, 1'b0);
    settle_block();
  endtask

  task automatic test_resync();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(HDR_BYTE);
    send_byte(8'h54);
    send_byte(HDR_BYTE);
    // its header lands where a type is due and restarts the frame
    send_frame(TYPE_ANGLE, 16'h1234, 16'hEDCB, 16'h0100, 16'hFF00, 1'b0);
    settle_block();
  endtask

  task automatic test_checksum_error();
    send_frame(TYPE_GYRO, 16'h4000, 16'hC000, 16'h0002, 16'h0F0F, 1'b1);
    send_frame(TYPE_ACCEL, 16'h0001, 16'hFFFE, 16'h2000, 16'h00FF, 1'b0);
    settle_block();
  endtask

  task automatic test_full_scale_traffic();
    write_cfg(CFG_ACCEL_FS, 13'd4096);
    write_cfg(CFG_GYRO_FS, 13'd1);
    write_cfg(CFG_ANGLE_FS, 13'd0);
    write_cfg(CFG_NONE, 13'h1FFF);
    run_traffic(0, 0, 400);
    write_cfg(CFG_ACCEL_FS, 13'h1FFF);
    write_cfg(CFG_GYRO_FS, 13'd4096);
    write_cfg(CFG_ANGLE_FS, 13'd1);
    write_cfg(CFG_NONE, 13'd0);
    run_traffic(82, 0, 400);
    write_cfg(CFG_ACCEL_FS, 13'($urandom_range(1, 4096)));
    write_cfg(CFG_GYRO_FS, 13'($urandom_range(1, 4096)));
    write_cfg(CFG_ANGLE_FS, 13'($urandom_range(1, 4096)));
    run_traffic(0, 82, 400);
    write_cfg(CFG_ACCEL_FS, 13'd0);
    write_cfg(CFG_GYRO_FS, 13'd5000);
    write_cfg(CFG_ANGLE_FS, 13'd4095);
    run_traffic(29, 29, 400);
  endtask

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= '0;
    cfg_data_i    <= '0;
    frame_pos  = POS_HDR;
    good_count = '0;
    bad_count  = '0;
    full_scale[CFG_ACCEL_FS] = FS_ACCEL_RST;
    full_scale[CFG_GYRO_FS]  = FS_GYRO_RST;
    full_scale[CFG_ANGLE_FS] = FS_ANGLE_RST;
    errors     = 0;
    bytes_sent = 0;
    idle_pct   = 0;
    stall_pct  = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_frame_kinds();
    test_resync();
    test_checksum_error();
    test_full_scale_traffic();

    repeat (10) @(posedge clk_i);
    if (frame_results_due.size() != 0) begin
      $display("%0t results missing: expected %0d more, actual 0", $time,
               frame_results_due.size());
      errors++;
    end
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
